### hdl/env_sensor_compensation_unit_assert.svh
// Assertion macros for the compensation unit
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ESC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define ESC_ASSERT_IMPL(label, clk, rst, prop)
`define ESC_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### hdl/esc_pkg.sv
`default_nettype none
package esc_pkg;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 64;
   localparam int DivStages = 32;
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_TEMP = 3'd0, REG_PLOW = 3'd1, REG_PHIGH = 3'd2,
      REG_PLAST = 3'd3, REG_HLOW = 3'd4, REG_HHIGH = 3'd5
   } reg_idx_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      asr = 32'($signed(x) >>> n);
   endfunction
endpackage
`default_nettype wire

### hdl/env_sensor_compensation_unit.sv
`default_nettype none
// Environmental sensor compensation unit (32-bit integer compensation).
// Input: pulse req_start with raw temperature, pressure and humidity while
// req_busy is low; busy is always low, so a transaction may start every cycle.
// Output: rsp_valid is high for exactly one cycle with compensated temperature
// (0.01 degC), pressure (Pa), humidity (1/1024 %RH) and a zero-divisor flag.
// The receiver cannot stall; results are never held back.
// Pipeline: 10 arithmetic stages, a 33-stage pipelined restoring divider,
// then 3 pressure correction stages.
// Throughput: one transaction per cycle; every stage takes new data each cycle.
// Trim coefficients live in six CSRs written over the csr_ channel; csr_ready is
// always high. The user must write only while the pipe is empty; unchecked.
// Reset: synchronous, clears trims to zero and empties the pipe; in-flight
// transactions are dropped.
// All intermediates wrap at 32 bits; signed shifts are arithmetic.
module env_sensor_compensation_unit
   import esc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_start,
   output logic                         req_busy,
   input  wire logic [19:0]             req_raw_temp,
   input  wire logic [19:0]             req_raw_press,
   input  wire logic [15:0]             req_raw_hum,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_temp_centi,
   output logic [31:0]                  rsp_press_pa,
   output logic [16:0]                  rsp_hum_q10,
   output logic                         rsp_press_div_zero,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);
`include "env_sensor_compensation_unit_assert.svh"

   // ---------------- CSRs ----------------
   logic [47:0] temp_trim_ff;
   logic [63:0] plow_ff, phigh_ff;
   logic [15:0] plast_ff;
   logic [31:0] hlow_ff, hhigh_ff;

   assign csr_ready = 1'b1;
   assign req_busy  = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0; plow_ff <= '0; phigh_ff <= '0;
         plast_ff <= '0; hlow_ff <= '0; hhigh_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP:  temp_trim_ff <= csr_wdata[47:0];
            REG_PLOW:  plow_ff      <= csr_wdata;
            REG_PHIGH: phigh_ff     <= csr_wdata;
            REG_PLAST: plast_ff     <= csr_wdata[15:0];
            REG_HLOW:  hlow_ff      <= csr_wdata[31:0];
            REG_HHIGH: hhigh_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // coefficient unpack to 32 bits (t1, p1, h1, h3 zero-extended, rest sign-extended)
   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   always_comb begin
      t1 = {16'd0, temp_trim_ff[15:0]};
      t2 = 32'($signed(temp_trim_ff[31:16]));
      t3 = 32'($signed(temp_trim_ff[47:32]));
      p1 = {16'd0, plow_ff[15:0]};
      p2 = 32'($signed(plow_ff[31:16]));
      p3 = 32'($signed(plow_ff[47:32]));
      p4 = 32'($signed(plow_ff[63:48]));
      p5 = 32'($signed(phigh_ff[15:0]));
      p6 = 32'($signed(phigh_ff[31:16]));
      p7 = 32'($signed(phigh_ff[47:32]));
      p8 = 32'($signed(phigh_ff[63:48]));
      p9 = 32'($signed(plast_ff));
      h1 = {24'd0, hlow_ff[7:0]};
      h2 = 32'($signed(hlow_ff[23:8]));
      h3 = {24'd0, hlow_ff[31:24]};
      h4 = 32'($signed(hhigh_ff[11:0]));
      h5 = 32'($signed(hhigh_ff[23:12]));
      h6 = 32'($signed(hhigh_ff[31:24]));
   end

   // ---------------- S1: temperature products ----------------
   logic        v1_ff;
   logic [31:0] s1_at2_ff, s1_bb_ff;
   logic [19:0] s1_rp_ff;
   logic [15:0] s1_rh_ff;
   logic [31:0] s1_a_in, s1_b_in;
   always_comb begin
      s1_a_in = {15'd0, req_raw_temp[19:3]} - (t1 << 1);
      s1_b_in = {16'd0, req_raw_temp[19:4]} - t1;
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0; else v1_ff <= req_start;
      s1_at2_ff <= s1_a_in * t2;
      s1_bb_ff  <= s1_b_in * s1_b_in;
      s1_rp_ff  <= req_raw_press;
      s1_rh_ff  <= req_raw_hum;
   end

   // ---------------- S2: v2 product ----------------
   logic        v2_ff;
   logic [31:0] s2_v1_ff, s2_bt3_ff;
   logic [19:0] s2_rp_ff;
   logic [15:0] s2_rh_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0; else v2_ff <= v1_ff;
      s2_v1_ff  <= asr(s1_at2_ff, 5'd11);
      s2_bt3_ff <= asr(s1_bb_ff, 5'd12) * t3;
      s2_rp_ff  <= s1_rp_ff;
      s2_rh_ff  <= s1_rh_ff;
   end

   // ---------------- S3: fine term ----------------
   logic        v3_ff;
   logic [31:0] s3_tf_ff;
   logic [19:0] s3_rp_ff;
   logic [15:0] s3_rh_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0; else v3_ff <= v2_ff;
      s3_tf_ff <= s2_v1_ff + asr(s2_bt3_ff, 5'd14);
      s3_rp_ff <= s2_rp_ff;
      s3_rh_ff <= s2_rh_ff;
   end

   // ---------------- S4: first product layer ----------------
   logic [31:0] s4_pv1, s4_q, s4_hv;
   always_comb begin
      s4_pv1 = asr(s3_tf_ff, 5'd1) - 32'd64000;
      s4_q   = asr(s4_pv1, 5'd2);
      s4_hv  = s3_tf_ff - 32'd76800;
   end
   logic        v4_ff;
   logic [31:0] s4_tf_ff, s4_pv1_ff, s4_qq_ff, s4_v1p5_ff, s4_p2v1_ff;
   logic [31:0] s4_hv_ff, s4_h5v_ff, s4_vh6_ff, s4_vh3_ff, s4_temp_ff;
   logic [19:0] s4_rp_ff;
   logic [15:0] s4_rh_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0; else v4_ff <= v3_ff;
      s4_tf_ff   <= s3_tf_ff;
      s4_temp_ff <= asr(s3_tf_ff * 32'd5 + 32'd128, 5'd8);
      s4_pv1_ff  <= s4_pv1;
      s4_qq_ff   <= s4_q * s4_q;
      s4_v1p5_ff <= s4_pv1 * p5;
      s4_p2v1_ff <= p2 * s4_pv1;
      s4_hv_ff   <= s4_hv;
      s4_h5v_ff  <= h5 * s4_hv;
      s4_vh6_ff  <= s4_hv * h6;
      s4_vh3_ff  <= s4_hv * h3;
      s4_rp_ff   <= s3_rp_ff;
      s4_rh_ff   <= s3_rh_ff;
   end

   // ---------------- S5 ----------------
   logic        v5_ff;
   logic [31:0] s5_v2a_ff, s5_p3q_ff, s5_p2v1_ff, s5_ha_ff, s5_hb_ff, s5_temp_ff;
   logic [19:0] s5_rp_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0; else v5_ff <= v4_ff;
      s5_v2a_ff  <= asr(s4_qq_ff, 5'd11) * p6 + (s4_v1p5_ff << 1);
      s5_p3q_ff  <= p3 * asr(s4_qq_ff, 5'd13);
      s5_p2v1_ff <= s4_p2v1_ff;
      s5_ha_ff   <= asr(({2'd0, s4_rh_ff, 14'd0}) - (h4 << 20) - s4_h5v_ff + 32'd16384,
                        5'd15);
      s5_hb_ff   <= asr(s4_vh6_ff, 5'd10) * (asr(s4_vh3_ff, 5'd11) + 32'd32768);
      s5_temp_ff <= s4_temp_ff;
      s5_rp_ff   <= s4_rp_ff;
   end

   // ---------------- S6 ----------------
   logic        v6_ff;
   logic [31:0] s6_v2_ff, s6_pv1_ff, s6_ha_ff, s6_hb_ff, s6_temp_ff;
   logic [19:0] s6_rp_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0; else v6_ff <= v5_ff;
      s6_v2_ff   <= asr(s5_v2a_ff, 5'd2) + (p4 << 16);
      s6_pv1_ff  <= asr(asr(s5_p3q_ff, 5'd3) + asr(s5_p2v1_ff, 5'd1), 5'd18);
      s6_ha_ff   <= s5_ha_ff;
      s6_hb_ff   <= (asr(s5_hb_ff, 5'd10) + 32'd2097152) * h2;
      s6_temp_ff <= s5_temp_ff;
      s6_rp_ff   <= s5_rp_ff;
   end

   // ---------------- S7 ----------------
   logic        v7_ff;
   logic [31:0] s7_den_ff, s7_pm_ff, s7_ha_ff, s7_hb_ff, s7_temp_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0; else v7_ff <= v6_ff;
      s7_den_ff  <= (32'd32768 + s6_pv1_ff) * p1;
      s7_pm_ff   <= (32'd1048576 - {12'd0, s6_rp_ff}) - asr(s6_v2_ff, 5'd12);
      s7_ha_ff   <= s6_ha_ff;
      s7_hb_ff   <= asr(s6_hb_ff + 32'd8192, 5'd14);
      s7_temp_ff <= s6_temp_ff;
   end

   // ---------------- S8 ----------------
   logic        v8_ff;
   logic [31:0] s8_den_ff, s8_p_ff, s8_hv_ff, s8_temp_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0; else v8_ff <= v7_ff;
      s8_den_ff  <= asr(s7_den_ff, 5'd15);
      s8_p_ff    <= s7_pm_ff * 32'd3125;
      s8_hv_ff   <= s7_ha_ff * s7_hb_ff;
      s8_temp_ff <= s7_temp_ff;
   end

   // ---------------- S9: humidity q*q ----------------
   logic        v9_ff;
   logic [31:0] s9_den_ff, s9_num_ff, s9_hv_ff, s9_qq_ff, s9_temp_ff;
   logic        s9_big_ff;
   logic [31:0] s9_q;
   assign s9_q = asr(s8_hv_ff, 5'd15);
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0; else v9_ff <= v8_ff;
      s9_den_ff  <= s8_den_ff;
      s9_big_ff  <= s8_p_ff[31];
      s9_num_ff  <= s8_p_ff[31] ? s8_p_ff : (s8_p_ff << 1);
      s9_hv_ff   <= s8_hv_ff;
      s9_qq_ff   <= s9_q * s9_q;
      s9_temp_ff <= s8_temp_ff;
   end

   // ---------------- S10: humidity finish ----------------
   logic        v10_ff;
   logic [31:0] s10_den_ff, s10_num_ff, s10_temp_ff;
   logic        s10_big_ff;
   logic [16:0] s10_hum_ff;
   logic [31:0] s10_v;
   always_comb begin
      s10_v = s9_hv_ff - asr(asr(s9_qq_ff, 5'd7) * h1, 5'd4);
      if (s10_v[31]) s10_v = '0;
      if (s10_v > 32'd419430400) s10_v = 32'd419430400;
   end
   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0; else v10_ff <= v9_ff;
      s10_den_ff  <= s9_den_ff;
      s10_num_ff  <= s9_num_ff;
      s10_big_ff  <= s9_big_ff;
      s10_hum_ff  <= s10_v[28:12];
      s10_temp_ff <= s9_temp_ff;
   end

   // ---------------- divider ----------------
   localparam int SideW = 1 + 1 + 17 + 32;
   logic             dv_valid;
   logic [31:0]      dv_quo;
   logic [SideW-1:0] dv_side;
   logic             s10_dz;
   assign s10_dz = (s10_den_ff == '0);

   esc_div #(.SideWidth(SideW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v10_ff),
      .in_num   (s10_num_ff),
      .in_den   (s10_dz ? 32'd1 : s10_den_ff),
      .in_side  ({s10_dz, s10_big_ff, s10_hum_ff, s10_temp_ff}),
      .out_valid(dv_valid),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // ---------------- P1: pressure products ----------------
   logic        pv1_ff, pz1_ff;
   logic [31:0] pp1_ff, pt1_ff, pss_ff, pp8_ff;
   logic [16:0] ph1_ff;
   logic [31:0] dq_p;
   assign dq_p = dv_side[SideW-2] ? (dv_quo << 1) : dv_quo;
   always_ff @(posedge clock) begin
      if (reset) pv1_ff <= 1'b0; else pv1_ff <= dv_valid;
      pz1_ff <= dv_side[SideW-1];
      pp1_ff <= dv_side[SideW-1] ? 32'd0 : dq_p;
      pss_ff <= {3'd0, dq_p[31:3]} * {3'd0, dq_p[31:3]};
      pp8_ff <= {2'd0, dq_p[31:2]} * p8;
      ph1_ff <= dv_side[48:32];
      pt1_ff <= dv_side[31:0];
   end

   // ---------------- P2 ----------------
   logic        pv2_ff, pz2_ff;
   logic [31:0] pp2_ff, pt2_ff, pa_ff, pb_ff;
   logic [16:0] ph2_ff;
   always_ff @(posedge clock) begin
      if (reset) pv2_ff <= 1'b0; else pv2_ff <= pv1_ff;
      pz2_ff <= pz1_ff;
      pp2_ff <= pp1_ff;
      pa_ff  <= asr(p9 * (pss_ff >> 13), 5'd12);
      pb_ff  <= asr(pp8_ff, 5'd13);
      ph2_ff <= ph1_ff;
      pt2_ff <= pt1_ff;
   end

   // ---------------- P3: output register ----------------
   logic        rv_ff, rz_ff;
   logic [31:0] rp_ff, rt_ff;
   logic [16:0] rh_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0; else rv_ff <= pv2_ff;
      rz_ff <= pz2_ff;
      rp_ff <= pz2_ff ? 32'd0 : pp2_ff + asr(pa_ff + pb_ff + p7, 5'd4);
      rh_ff <= ph2_ff;
      rt_ff <= pt2_ff;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_temp_centi     = $signed(rt_ff);
   assign rsp_press_pa       = rp_ff;
   assign rsp_hum_q10        = rh_ff;
   assign rsp_press_div_zero = rz_ff;

   // ---------------- assertions ----------------
   `ESC_ASSERT_NEVER(a_hum_range, clock, reset, rsp_valid && rsp_hum_q10 > 17'd102400)
   `ESC_ASSERT_NEVER(a_dz_zero, clock, reset, rsp_valid && rsp_press_div_zero && |rsp_press_pa)
   `ESC_ASSERT_IMPL(a_div_flow, clock, reset, dv_valid |=> pv1_ff)
endmodule
`default_nettype wire

### hdl/esc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage; carries side payload.
module esc_div
   import esc_pkg::*;
#(
   parameter int SideWidth = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [31:0]          in_num,
   input  wire logic [31:0]          in_den,
   input  wire logic [SideWidth-1:0] in_side,
   output logic                      out_valid,
   output logic [31:0]               out_quo,
   output logic [SideWidth-1:0]      out_side
);
   logic [DivStages:0]           vld_ff;
   logic [31:0]                  rem_ff [DivStages+1];
   logic [31:0]                  quo_ff [DivStages+1];
   logic [31:0]                  den_ff [DivStages+1];
   logic [SideWidth-1:0]         side_ff [DivStages+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[DivStages-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      quo_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      logic [32:0] trial;
      logic [32:0] shifted;
      always_comb begin
         shifted = {rem_ff[s], quo_ff[s][31]};
         trial   = shifted - {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (!trial[32]) begin
            rem_ff[s+1] <= trial[31:0];
            quo_ff[s+1] <= {quo_ff[s][30:0], 1'b1};
         end else begin
            rem_ff[s+1] <= shifted[31:0];
            quo_ff[s+1] <= {quo_ff[s][30:0], 1'b0};
         end
         den_ff[s+1]  <= den_ff[s];
         side_ff[s+1] <= side_ff[s];
      end
   end

   assign out_valid = vld_ff[DivStages];
   assign out_quo   = quo_ff[DivStages];
   assign out_side  = side_ff[DivStages];
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;
   import esc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // csr indexes outside the register map; writes there must be dropped
   localparam logic [CsrIdxWidth-1:0] IdxSpare0 = 3'd6;
   localparam logic [CsrIdxWidth-1:0] IdxSpare1 = 3'd7;
   // leave margin beyond the pipe latency for settling and the tail
   localparam int SettleCycles = 60;
   // quiet cycles allowed before the run is declared hung
   localparam int HangLimit = 2000;

   typedef struct packed {
      logic [31:0] temp_centi;
      logic [31:0] press_pa;
      logic [16:0] hum_q10;
      logic        div_zero;
   } comp_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        req_busy;
   logic [19:0] req_raw_temp = '0;
   logic [19:0] req_raw_press = '0;
   logic [15:0] req_raw_hum = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_temp_centi;
   logic [31:0] rsp_press_pa;
   logic [16:0] rsp_hum_q10;
   logic        rsp_press_div_zero;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index = REG_TEMP;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // local copy of the trim registers
   logic [47:0] trim_temp;
   logic [63:0] trim_plow, trim_phigh;
   logic [15:0] trim_plast;
   logic [31:0] trim_hlow, trim_hhigh;

   comp_result_t expected_results[$];
   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  idle_enable = 1'b1;
   // values seen at the falling edge, i.e. what the next rising edge will use
   logic busy_seen, csr_ready_seen;

   env_sensor_compensation_unit uut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: 32-bit wrapping integer compensation
   // ---------------------------------------------------------------------
   function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic comp_result_t compensate(input logic [19:0] raw_t,
                                               input logic [19:0] raw_p,
                                               input logic [15:0] raw_h);
      logic [31:0] rt, rp, rh;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, v1, v2, tf, q, p, v, sq, m;
      comp_result_t r;
      rt = {12'd0, raw_t};
      rp = {12'd0, raw_p};
      rh = {16'd0, raw_h};
      t1 = {16'd0, trim_temp[15:0]};
      t2 = sext16(trim_temp[31:16]);
      t3 = sext16(trim_temp[47:32]);
      p1 = {16'd0, trim_plow[15:0]};
      p2 = sext16(trim_plow[31:16]);
      p3 = sext16(trim_plow[47:32]);
      p4 = sext16(trim_plow[63:48]);
      p5 = sext16(trim_phigh[15:0]);
      p6 = sext16(trim_phigh[31:16]);
      p7 = sext16(trim_phigh[47:32]);
      p8 = sext16(trim_phigh[63:48]);
      p9 = sext16(trim_plast);
      h1 = {24'd0, trim_hlow[7:0]};
      h2 = sext16(trim_hlow[23:8]);
      h3 = {24'd0, trim_hlow[31:24]};
      h4 = {{20{trim_hhigh[11]}}, trim_hhigh[11:0]};
      h5 = {{20{trim_hhigh[23]}}, trim_hhigh[23:12]};
      h6 = {{24{trim_hhigh[31]}}, trim_hhigh[31:24]};

      // temperature and fine term
      a = (rt >> 3) - (t1 << 1);
      m = a * t2;
      v1 = sra32(m, 11);
      b = (rt >> 4) - t1;
      m = b * b;
      m = sra32(m, 12) * t3;
      v2 = sra32(m, 14);
      tf = v1 + v2;
      m = tf * 32'd5 + 32'd128;
      r.temp_centi = sra32(m, 8);

      // pressure
      v1 = sra32(tf, 1) - 32'd64000;
      q = sra32(v1, 2);
      sq = q * q;
      v2 = sra32(sq, 11) * p6;
      m = v1 * p5;
      v2 = v2 + (m << 1);
      v2 = sra32(v2, 2) + (p4 << 16);
      m = p3 * sra32(sq, 13);
      a = p2 * v1;
      m = sra32(m, 3) + sra32(a, 1);
      v1 = sra32(m, 18);
      m = (32'd32768 + v1) * p1;
      v1 = sra32(m, 15);
      r.div_zero = (v1 == 32'd0);
      if (r.div_zero) begin
         p = 32'd0;
      end else begin
         p = ((32'd1048576 - rp) - sra32(v2, 12)) * 32'd3125;
         if (p < 32'h8000_0000) begin
            p = (p << 1) / v1;
         end else begin
            p = (p / v1) * 32'd2;
         end
         m = (p >> 3) * (p >> 3);
         m = m >> 13;
         m = p9 * m;
         v1 = sra32(m, 12);
         m = (p >> 2) * p8;
         v2 = sra32(m, 13);
         p = p + sra32(v1 + v2 + p7, 4);
      end
      r.press_pa = p;

      // humidity
      v = tf - 32'd76800;
      m = (rh << 14) - (h4 << 20) - (h5 * v) + 32'd16384;
      a = sra32(m, 15);
      m = v * h6;
      b = v * h3;
      b = sra32(m, 10) * (sra32(b, 11) + 32'd32768);
      m = (sra32(b, 10) + 32'd2097152) * h2 + 32'd8192;
      b = sra32(m, 14);
      v = a * b;
      q = sra32(v, 15);
      m = q * q;
      m = sra32(m, 7) * h1;
      v = v - sra32(m, 4);
      if (v[31]) v = 32'd0;
      if (v > 32'd419430400) v = 32'd419430400;
      m = v >> 12;
      r.hum_q10 = m[16:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sampling, checking and watchdog (all at the falling edge, away from
   // the rising edge where both sides update)
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got 0x%08h expected 0x%08h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(negedge clock) begin
      comp_result_t want;
      busy_seen <= req_busy;
      csr_ready_seen <= csr_ready;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_start && !req_busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= HangLimit) begin
            $display("tb: failure");
            $finish;
         end
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("mismatch: result with no transaction outstanding at %0t", $realtime);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_temp_centi !== want.temp_centi)
                  report_mismatch("temp_centi", rsp_temp_centi, want.temp_centi);
               if (rsp_press_pa !== want.press_pa)
                  report_mismatch("press_pa", rsp_press_pa, want.press_pa);
               if (rsp_hum_q10 !== want.hum_q10)
                  report_mismatch("hum_q10", {15'd0, rsp_hum_q10}, {15'd0, want.hum_q10});
               if (rsp_press_div_zero !== want.div_zero)
                  report_mismatch("press_div_zero", {31'd0, rsp_press_div_zero},
                                  {31'd0, want.div_zero});
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: every task starts and ends just after a rising edge
   // ---------------------------------------------------------------------
   // Send one measurement transaction; start stays high for back-to-back use.
   task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                              input logic [15:0] rh);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_start <= 1'b1;
      req_raw_temp <= rt;
      req_raw_press <= rp;
      req_raw_hum <= rh;
      forever begin
         @(posedge clock);
         if (!busy_seen) break;
      end
      expected_results.push_back(compensate(rt, rp, rh));
   endtask

   // Wait for the pipe to drain, then wait SettleCycles more as margin.
   task automatic settle();
      req_start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_trim(input logic [CsrIdxWidth-1:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      forever begin
         @(posedge clock);
         if (csr_ready_seen) break;
      end
      csr_valid <= 1'b0;
      case (idx)
         REG_TEMP:  trim_temp = data[47:0];
         REG_PLOW:  trim_plow = data;
         REG_PHIGH: trim_phigh = data;
         REG_PLAST: trim_plast = data[15:0];
         REG_HLOW:  trim_hlow = data[31:0];
         REG_HHIGH: trim_hhigh = data[31:0];
         default: ;
      endcase
   endtask

   task automatic load_trims(input logic [47:0] t, input logic [63:0] pl,
                             input logic [63:0] ph, input logic [15:0] p9,
                             input logic [31:0] hl, input logic [31:0] hh);
      settle();
      write_trim(REG_TEMP, {16'd0, t});
      write_trim(REG_PLOW, pl);
      write_trim(REG_PHIGH, ph);
      write_trim(REG_PLAST, {48'd0, p9});
      write_trim(REG_HLOW, {32'd0, hl});
      write_trim(REG_HHIGH, {32'd0, hh});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // typical factory trim values
   task automatic load_typical_trims();
      load_trims({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 16'd6000,
                 {8'd0, 16'd362, 8'd75},
                 {8'd30, 12'd0, 12'd324});
   endtask

   task automatic send_random(input int count);
      repeat (count) send_sample(20'($urandom), 20'($urandom), 16'($urandom));
   endtask

   // plausible raw readings around room conditions, with random spread
   task automatic send_plausible(input int count);
      repeat (count)
         send_sample(20'($urandom_range(380000, 620000)),
                     20'($urandom_range(250000, 450000)),
                     16'($urandom_range(20000, 40000)));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset trims are zero: the pressure divisor is zero for every input.
   task automatic test_reset_trims();
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'h80000, 20'h7FFFF, 16'h8000);
      send_random(5);
   endtask

   task automatic test_field_extremes();
      load_typical_trims();
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample('0, '1, 16'h0000);
      send_sample('1, '0, 16'hFFFF);
      send_sample(20'd519888, 20'd415148, 16'd0);
      send_sample(20'd519888, 20'd415148, 16'hFFFF);
      send_sample(20'hAAAAA, 20'h55555, 16'hA5A5);
      send_sample(20'h55555, 20'hAAAAA, 16'h5A5A);
   endtask

   // P1 of zero forces the divisor to zero with otherwise plausible trims.
   task automatic test_zero_divisor();
      load_typical_trims();
      write_trim(REG_PLOW, {trim_plow[63:16], 16'd0});
      send_plausible(4);
      send_sample('1, '0, '1);
   endtask

   // large H2 and H1 push humidity past both clamp limits
   task automatic test_humidity_clamp();
      load_typical_trims();
      write_trim(REG_HLOW, {32'd0, 8'd255, 16'h7FFF, 8'd255});
      send_sample(20'd519888, 20'd415148, 16'hFFFF);
      send_sample(20'd519888, 20'd415148, 16'd0);
      settle();
      write_trim(REG_HLOW, {32'd0, 8'd0, 16'h7FFF, 8'd0});
      send_sample(20'd519888, 20'd415148, 16'hFFFF);
      send_sample(20'd519888, 20'd415148, 16'd1000);
   endtask

   // writes to indexes beyond the map must leave the trims alone
   task automatic test_spare_index();
      settle();
      write_trim(IdxSpare0, '1);
      write_trim(IdxSpare1, 64'h1234_5678_9ABC_DEF0);
      send_plausible(3);
   endtask

   task automatic test_trim_extremes();
      load_trims('1, '1, '1, '1, '1, '1);
      send_random(40);
      load_trims({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h8000}},
                 16'h8000, {8'hFF, 16'h8000, 8'hFF}, {8'h80, 12'h800, 12'h800});
      send_random(40);
      load_trims({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'hFFFF},
                 {4{16'h7FFF}}, 16'h7FFF, {8'h00, 16'h7FFF, 8'h00},
                 {8'h7F, 12'h7FF, 12'h7FF});
      send_random(40);
   endtask

   task automatic test_random_trims();
      repeat (8) begin
         load_trims(48'(rand64()), rand64(), rand64(), 16'($urandom),
                    $urandom, $urandom);
         send_random(100);
      end
   endtask

   task automatic test_typical_random();
      load_typical_trims();
      send_plausible(500);
      send_random(200);
   endtask

   // last stretch back to back, no idling
   task automatic test_streaming();
      settle();
      idle_enable = 1'b0;
      load_trims(48'(rand64()), rand64(), rand64(), 16'($urandom), $urandom, $urandom);
      send_random(150);
      load_typical_trims();
      send_plausible(150);
   endtask

   initial begin
      trim_temp = '0;
      trim_plow = '0;
      trim_phigh = '0;
      trim_plast = '0;
      trim_hlow = '0;
      trim_hhigh = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_trims();
      test_field_extremes();
      test_zero_divisor();
      test_humidity_clamp();
      test_spare_index();
      test_trim_extremes();
      test_random_trims();
      test_typical_random();
      test_streaming();
      settle();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
